// ===== rtl/core/phs_pkg.sv =====
// ----------------------------------------------------------------------------
// phs_pkg: shared types and constants for the pointer hash set
// Table geometry, key markers, opcodes and the 32-bit key mix constants.
// ----------------------------------------------------------------------------
package phs_pkg;

	localparam int TABLE_SLOTS = 64;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
	localparam int LOAD_LIMIT  = TABLE_SLOTS - TABLE_SLOTS / 4;

	localparam int KEY_W   = 64;
	localparam int LIVE_W  = 7;
	localparam int S_DATA_W = 72;  // opcode + key, padded to bytes
	localparam int M_DATA_W = 16;  // existed + rejected + live_count, padded

	localparam logic [KEY_W-1:0] KEY_EMPTY = '0;
	localparam logic [KEY_W-1:0] KEY_TOMB  = '1;

	localparam logic [31:0] HASH_C1 = 32'h85EB_CA6B;
	localparam logic [31:0] HASH_C2 = 32'hC2B2_AE35;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_EXISTS = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

endpackage

// ===== rtl/core/pointer_hash_set_linear_probe_top.sv =====
// ----------------------------------------------------------------------------
// pointer_hash_set_linear_probe_top: open-addressed 64-bit key set
// Linear probing with tombstones over a synchronous slot RAM with one read and one write port;
// the key hash is a two-multiply 32-bit mix computed in ST_HASH1, ST_HASH2 and ST_HASH3.
//
// Channel  Dir  Fields (low bit up)
// s_*      in   opcode[1:0], key[65:2], zero pad to 72 bits
// m_*      out  existed[0], rejected[1], live_count[8:2], zero pad to 16 bits
//
// Insert/exists/remove: the hash states, then P probes, P = slots probed (1..64);
// the RAM read per probe sets the pace. Clear and reserved keys go straight to ST_RESULT.
// One request in flight; s_tready is high only when the sequencer is idle.
// A stalled result holds in the output register; the next request is still
// taken, and its result waits until the register drains.
// Reset empties the table at once through per-slot valid flops.
// ----------------------------------------------------------------------------
module pointer_hash_set_linear_probe_top
	import phs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // opcode[1:0], key[65:2]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata   // existed[0], rejected[1], live_count[8:2]
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH1,
		ST_HASH2,
		ST_HASH3,
		ST_PROBE,
		ST_RESULT
	} state_t;

	state_t state_q;

	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [31:0]      mix1_q, mix2_q;
	logic [SLOT_W-1:0] pos_q, step_q, free_pos_q;
	logic              free_found_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              existed_q, rejected_q;
	logic              m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	// slot RAM plus per-slot valid flops (invalid reads as empty)
	logic [KEY_W-1:0]       mem [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [KEY_W-1:0]       rd_q;
	logic                   rdv_q;
	logic                   mem_we;
	logic [SLOT_W-1:0]      mem_wa, mem_ra;
	logic [KEY_W-1:0]       mem_wd;

	op_t              in_op;
	logic [KEY_W-1:0] in_key;
	logic             in_fire, in_reserved;
	logic [31:0]      fold, h1, h2, h3;
	logic [KEY_W-1:0] slot_val;
	logic             hit, stop_miss, last_step, slot_free;
	logic             out_free;
	logic [CNT_W+LIVE_W-1:0] cnt_ext;

	assign in_op       = op_t'(s_tdata[1:0]);
	assign in_key      = s_tdata[KEY_W+1:2];
	assign s_tready    = (state_q == ST_IDLE);
	assign in_fire     = s_tvalid && s_tready;
	assign in_reserved = (in_key == KEY_EMPTY) || (in_key == KEY_TOMB);

	assign fold = key_q[63:32] ^ key_q[31:0];
	assign h1   = fold ^ (fold >> 16);
	assign h2   = mix1_q ^ (mix1_q >> 13);
	assign h3   = mix2_q ^ (mix2_q >> 16);

	assign slot_val  = rdv_q ? rd_q : KEY_EMPTY;
	assign hit       = (slot_val == key_q);
	assign slot_free = (slot_val == KEY_EMPTY) || (slot_val == KEY_TOMB);
	assign last_step = (step_q == SLOT_W'(TABLE_SLOTS - 1));
	assign stop_miss = !hit && ((slot_val == KEY_EMPTY) || last_step);
	assign out_free  = !m_tvalid_q || m_tready;

	assign cnt_ext  = {{LIVE_W{1'b0}}, cnt_q};
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// read address: hash start, then the next slot while probing
	always_comb begin
		mem_ra = pos_q;
		if (state_q == ST_HASH3) begin
			mem_ra = h3[SLOT_W-1:0];
		end else if (state_q == ST_PROBE) begin
			mem_ra = pos_q + 1'b1;
		end
	end

	// final write: tombstone on remove hit, key on insert into first free slot
	always_comb begin
		mem_we = 1'b0;
		mem_wa = pos_q;
		mem_wd = KEY_TOMB;
		if (state_q == ST_PROBE) begin
			if (hit && op_q == OP_REMOVE) begin
				mem_we = 1'b1;
			end else if (stop_miss && op_q == OP_INSERT
					&& cnt_q < CNT_W'(LOAD_LIMIT)
					&& (free_found_q || slot_free)) begin
				mem_we = 1'b1;
				mem_wa = free_found_q ? free_pos_q : pos_q;
				mem_wd = key_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_q   <= 1'b0;
		end else begin
			rdv_q <= valid_q[mem_ra] || (mem_we && mem_wa == mem_ra);
			if (in_fire && in_op == OP_CLEAR) begin
				valid_q <= '0;
			end else if (mem_we) begin
				valid_q[mem_wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_INSERT;
			key_q        <= '0;
			mix1_q       <= '0;
			mix2_q       <= '0;
			pos_q        <= '0;
			step_q       <= '0;
			free_pos_q   <= '0;
			free_found_q <= 1'b0;
			cnt_q        <= '0;
			existed_q    <= 1'b0;
			rejected_q   <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			// the result state reloads the output register itself
			if (m_tready && state_q != ST_RESULT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q       <= in_op;
						key_q      <= in_key;
						existed_q  <= 1'b0;
						rejected_q <= 1'b0;
						if (in_op == OP_CLEAR) begin
							cnt_q   <= '0;
							state_q <= ST_RESULT;
						end else if (in_reserved) begin
							rejected_q <= (in_op == OP_INSERT);
							state_q    <= ST_RESULT;
						end else begin
							state_q <= ST_HASH1;
						end
					end
				end
				ST_HASH1: begin
					mix1_q  <= h1 * HASH_C1;
					state_q <= ST_HASH2;
				end
				ST_HASH2: begin
					mix2_q  <= h2 * HASH_C2;
					state_q <= ST_HASH3;
				end
				ST_HASH3: begin
					pos_q        <= h3[SLOT_W-1:0];
					step_q       <= '0;
					free_found_q <= 1'b0;
					state_q      <= ST_PROBE;
				end
				ST_PROBE: begin
					if (hit) begin
						existed_q <= 1'b1;
						if (op_q == OP_REMOVE && cnt_q != '0) begin
							cnt_q <= cnt_q - 1'b1;
						end
						state_q <= ST_RESULT;
					end else if (stop_miss) begin
						if (op_q == OP_INSERT) begin
							if (mem_we) begin
								cnt_q <= cnt_q + 1'b1;
							end else begin
								rejected_q <= 1'b1;
							end
						end
						state_q <= ST_RESULT;
					end else begin
						// remember first tombstone for a later insert
						if (slot_val == KEY_TOMB && !free_found_q) begin
							free_found_q <= 1'b1;
							free_pos_q   <= pos_q;
						end
						pos_q  <= pos_q + 1'b1;
						step_q <= step_q + 1'b1;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_DATA_W'({cnt_ext[LIVE_W-1:0], rejected_q, existed_q});
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_load_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LOAD_LIMIT))
		else $error("live count above load limit");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_op == OP_CLEAR) |=> (cnt_q == '0 && valid_q == '0))
		else $error("clear did not empty the table");

	a_write_in_probe: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_PROBE && (hit || stop_miss)))
		else $error("slot write outside end of probe");

	a_result_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && !out_free) |=> (state_q == ST_RESULT))
		else $error("result dropped while output stalled");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the linear-probe pointer hash set
// Drives insert/exists/remove/clear requests, keeps a shadow copy of the slot
// table to predict existed/rejected/live_count, and compares every response.
// ----------------------------------------------------------------------------
module tb_top
	import phs_pkg::*;
();

	typedef struct packed {
		logic              existed;
		logic              rejected;
		logic [LIVE_W-1:0] live_count;
	} set_resp_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic             known;
		set_resp_t        resp;
	} dir_row_t;

	typedef enum int {
		MODE_GROW,
		MODE_CHURN,
		MODE_SHRINK
	} mix_mode_t;

	localparam int RAND_ITEMS   = 1830;
	localparam int CALM_AFTER   = 1650;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 250;
	localparam int DRAIN_CYCLES = 80;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;

	// typed expectation travelling alongside the request on the bus
	logic      req_known;
	set_resp_t req_resp;

	bit calm;
	bit hold_req;
	int fail_cnt;

	set_resp_t        resp_q[$];
	logic [KEY_W-1:0] shadow_slots [TABLE_SLOTS];
	int               shadow_live;
	logic [KEY_W-1:0] key_pool[$];

	// fold values shared by colliding keys: hi ^ lo lands on the same hash
	logic [31:0] fold_set [4] = '{32'h0000_0000, 32'h0000_0040, 32'h1234_5678, 32'hFFFF_FFC0};

	dir_row_t dir_rows [23] = '{
		'{OP_EXISTS, 64'd1,                    1'b1, '{1'b0, 1'b0, 7'd0}},
		'{OP_INSERT, 64'd0,                    1'b1, '{1'b0, 1'b1, 7'd0}},
		'{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF,  1'b1, '{1'b0, 1'b1, 7'd0}},
		'{OP_REMOVE, 64'd0,                    1'b1, '{1'b0, 1'b0, 7'd0}},
		'{OP_EXISTS, 64'hFFFF_FFFF_FFFF_FFFF,  1'b1, '{1'b0, 1'b0, 7'd0}},
		'{OP_INSERT, 64'd1,                    1'b1, '{1'b0, 1'b0, 7'd1}},
		'{OP_INSERT, 64'd1,                    1'b1, '{1'b1, 1'b0, 7'd1}},
		'{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFE,  1'b1, '{1'b0, 1'b0, 7'd2}},
		'{OP_EXISTS, 64'hFFFF_FFFF_FFFF_FFFE,  1'b1, '{1'b1, 1'b0, 7'd2}},
		'{OP_REMOVE, 64'd1,                    1'b1, '{1'b1, 1'b0, 7'd1}},
		'{OP_REMOVE, 64'd1,                    1'b1, '{1'b0, 1'b0, 7'd1}},
		'{OP_EXISTS, 64'd1,                    1'b1, '{1'b0, 1'b0, 7'd1}},
		'{OP_INSERT, 64'd1,                    1'b1, '{1'b0, 1'b0, 7'd2}},
		'{OP_INSERT, 64'h8000_0000_0000_0000,  1'b1, '{1'b0, 1'b0, 7'd3}},
		'{OP_INSERT, 64'h0000_0001_0000_0001,  1'b1, '{1'b0, 1'b0, 7'd4}},
		'{OP_INSERT, 64'hDEAD_BEEF_DEAD_BEEF,  1'b1, '{1'b0, 1'b0, 7'd5}},
		'{OP_REMOVE, 64'h0000_0001_0000_0001,  1'b1, '{1'b1, 1'b0, 7'd4}},
		// probe must walk past the tombstone left above
		'{OP_EXISTS, 64'hDEAD_BEEF_DEAD_BEEF,  1'b0, '{1'b0, 1'b0, 7'd0}},
		'{OP_INSERT, 64'h0000_0002_0000_0002,  1'b0, '{1'b0, 1'b0, 7'd0}},
		'{OP_EXISTS, 64'h5555_5555_AAAA_AAAA,  1'b0, '{1'b0, 1'b0, 7'd0}},
		'{OP_CLEAR,  64'd0,                    1'b1, '{1'b0, 1'b0, 7'd0}},
		'{OP_CLEAR,  64'hFFFF_FFFF_FFFF_FFFF,  1'b1, '{1'b0, 1'b0, 7'd0}},
		'{OP_EXISTS, 64'hDEAD_BEEF_DEAD_BEEF,  1'b1, '{1'b0, 1'b0, 7'd0}}
	};

	pointer_hash_set_linear_probe_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // opcode[1:0], key[65:2]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // existed[0], rejected[1], live_count[8:2]
	);

	function automatic logic [31:0] key_mix(logic [KEY_W-1:0] k);
		logic [31:0] h;
		h = k[63:32] ^ k[31:0];
		h = h ^ (h >> 16);
		h = h * HASH_C1;
		h = h ^ (h >> 13);
		h = h * HASH_C2;
		h = h ^ (h >> 16);
		return h;
	endfunction

	// updates the shadow table and returns the response for one request
	function automatic set_resp_t apply_request(op_t op, logic [KEY_W-1:0] key);
		set_resp_t r;
		logic [31:0] h;
		int start;
		int pos;
		int hit;
		int slot;
		bit stop;
		r = '0;
		if (op == OP_CLEAR) begin
			foreach (shadow_slots[i]) shadow_slots[i] = KEY_EMPTY;
			shadow_live = 0;
		end else if (key == KEY_EMPTY || key == KEY_TOMB) begin
			r.rejected = (op == OP_INSERT);
		end else begin
			h = key_mix(key);
			start = int'(h[SLOT_W-1:0]);
			hit = -1;
			pos = start;
			stop = 0;
			for (int n = 0; n < TABLE_SLOTS && !stop; n++) begin
				if (shadow_slots[pos] == key) begin
					hit = pos;
					stop = 1;
				end else if (shadow_slots[pos] == KEY_EMPTY) begin
					stop = 1;
				end else begin
					pos = (pos + 1) % TABLE_SLOTS;
				end
			end
			r.existed = (hit >= 0);
			if (op == OP_INSERT && hit < 0) begin
				if (shadow_live >= LOAD_LIMIT) begin
					r.rejected = 1'b1;
				end else begin
					slot = -1;
					pos = start;
					for (int n = 0; n < TABLE_SLOTS && slot < 0; n++) begin
						if (shadow_slots[pos] == KEY_EMPTY || shadow_slots[pos] == KEY_TOMB)
							slot = pos;
						else
							pos = (pos + 1) % TABLE_SLOTS;
					end
					if (slot < 0) begin
						r.rejected = 1'b1;
					end else begin
						shadow_slots[slot] = key;
						shadow_live++;
					end
				end
			end else if (op == OP_REMOVE && hit >= 0) begin
				shadow_slots[hit] = KEY_TOMB;
				shadow_live--;
			end
		end
		r.live_count = shadow_live[LIVE_W-1:0];
		return r;
	endfunction

	function automatic op_t pick_op(mix_mode_t mode);
		int r;
		int ins_lim;
		int ex_lim;
		r = $urandom_range(0, 199);
		case (mode)
			MODE_GROW: begin
				ins_lim = 130;
				ex_lim  = 165;
			end
			MODE_CHURN: begin
				ins_lim = 80;
				ex_lim  = 130;
			end
			default: begin
				ins_lim = 40;
				ex_lim  = 80;
			end
		endcase
		if (r < ins_lim)
			return OP_INSERT;
		else if (r < ex_lim)
			return OP_EXISTS;
		else if (r < 199)
			return OP_REMOVE;
		else
			return OP_CLEAR;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int sel;
		logic [31:0] hi;
		sel = $urandom_range(0, 99);
		hi = $urandom;
		if (sel < 3)
			return KEY_EMPTY;
		else if (sel < 6)
			return KEY_TOMB;
		else if (sel < 45 && key_pool.size() > 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		else if (sel < 62)
			return {hi, hi ^ fold_set[$urandom_range(0, 3)]};
		else
			return {hi, 32'($urandom)};
	endfunction

	task automatic send_request(op_t op, logic [KEY_W-1:0] key, logic known, set_resp_t resp);
		s_tvalid  <= 1'b1;
		s_tdata   <= {{(S_DATA_W - KEY_W - 2){1'b0}}, key, op};
		req_known <= known;
		req_resp  <= resp;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_gap(int pct);
		if (!calm && $urandom_range(0, 99) < pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	// response checker and request predictor share one edge-sampled block
	always @(posedge clk) begin : scoreboard
		set_resp_t want;
		set_resp_t got;
		set_resp_t pred;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.existed    = m_tdata[0];
				got.rejected   = m_tdata[1];
				got.live_count = m_tdata[LIVE_W+1:2];
				if (resp_q.size() == 0) begin
					$error("response with no request pending: m_tdata=%h", m_tdata);
					fail_cnt++;
				end else begin
					want = resp_q.pop_front();
					if (got.existed !== want.existed) begin
						$error("existed: expected %0d, got %0d", want.existed, got.existed);
						fail_cnt++;
					end
					if (got.rejected !== want.rejected) begin
						$error("rejected: expected %0d, got %0d", want.rejected, got.rejected);
						fail_cnt++;
					end
					if (got.live_count !== want.live_count) begin
						$error("live_count: expected %0d, got %0d",
							want.live_count, got.live_count);
						fail_cnt++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				pred = apply_request(op_t'(s_tdata[1:0]), s_tdata[KEY_W+1:2]);
				resp_q.push_back(req_known ? req_resp : pred);
			end
		end
	end

	// response side backpressure
	initial begin
		bit hold_done;
		hold_done = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				// long stall: block fills and drops s_tready while requests keep coming
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		int rand_cnt;
		int phase;
		int plen;
		int idle_pct;
		mix_mode_t mode;
		op_t op;
		logic [KEY_W-1:0] key;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		req_known <= 1'b0;
		req_resp  <= '0;
		calm      = 0;
		hold_req  = 0;
		fail_cnt  = 0;
		shadow_live = 0;
		foreach (shadow_slots[i]) shadow_slots[i] = KEY_EMPTY;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].known, dir_rows[i].resp);
			idle_gap(30);
		end

		// phases: two growth runs push load to the limit, then churn, then shrink
		rand_cnt = 0;
		phase = 0;
		while (rand_cnt < RAND_ITEMS) begin
			case (phase % 4)
				0, 1: mode = MODE_GROW;
				2: mode = MODE_CHURN;
				default: mode = MODE_SHRINK;
			endcase
			plen = $urandom_range(120, 260);
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 25;
				default: idle_pct = 50;
			endcase
			if (phase % 4 == 0 && $urandom_range(0, 1) == 1) begin
				send_request(OP_CLEAR, {32'($urandom), 32'($urandom)}, 1'b0, '0);
				idle_gap(idle_pct);
				rand_cnt++;
			end
			for (int i = 0; i < plen && rand_cnt < RAND_ITEMS; i++) begin
				op = pick_op(mode);
				key = pick_key();
				if (op == OP_INSERT && key != KEY_EMPTY && key != KEY_TOMB) begin
					key_pool.push_back(key);
					if (key_pool.size() > 64)
						void'(key_pool.pop_front());
				end
				if (rand_cnt == HOLD_AT)
					hold_req = 1;
				if (rand_cnt == CALM_AFTER)
					calm = 1;
				send_request(op, key, 1'b0, '0);
				idle_gap(idle_pct);
				rand_cnt++;
			end
			phase++;
		end
		s_tvalid <= 1'b0;

		while (resp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
